// ===== design/assert_macros.svh =====
// Assertion macros used by the predictor top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tbbp_pkg.sv =====
// Types, constants and helper functions of the two-bit branch predictor.
package tbbp_pkg;

  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned DIGIT_W     = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [1:0]       CTR_MIN   = 2'd0;
  localparam logic [1:0]       CTR_MAX   = 2'd3;
  localparam logic [1:0]       CTR_TAKEN = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] branch_address;
    logic              was_taken;
  } in_word_t;

  typedef struct packed {
    logic             predicted_taken;
    logic             prediction_right;
    logic             index_collision;
    logic [CNT_W-1:0] right_total;
    logic [CNT_W-1:0] wrong_total;
    logic [CNT_W-1:0] collision_total;
  } out_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_flags_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_REDUCE,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_UPDATE
  } back_state_e;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [1:0] ctr_step(input logic [1:0] c, input logic taken);
    logic [1:0] n;
    if (taken) begin
      n = (c == CTR_MAX) ? c : c + 1'b1;
    end else begin
      n = (c == CTR_MIN) ? c : c - 1'b1;
    end
    return n;
  endfunction

endpackage

// ===== design/two_bit_branch_predictor_unit.sv =====
// Bimodal predictor with 2-bit saturating counters, tag check and statistics.
//
// Input channel (in_valid_i / in_stall_o / in_word_i): one resolved branch per
// word, its address and actual outcome. Output channel (out_valid_o /
// out_stall_i / out_word_o): one result word per input word, in order, with
// the prediction, its correctness, the tag collision flag and the three
// saturating totals after the update.
// Power-of-two table sizes take the index from the low address bits; other
// sizes reduce the address modulo TABLE_ENTRIES in the front first.
// The back takes a new word only after it has updated the tables for the last
// one (read-modify-write: registered read, then update). For non-power-of-two
// sizes the front's digit-serial index reduction holds in_stall_o high as well.
// Reset: the tables are swept to zero, one entry per cycle; in_stall_o stays
// high during the sweep.
// A stalled result holds in the output register; a two-word queue between
// front and back keeps accepting input until it fills.
`include "assert_macros.svh"

module two_bit_branch_predictor_unit #(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned ADDRESS_BITS  = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tbbp_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tbbp_pkg::out_word_t out_word_o
);
  import tbbp_pkg::*;

  localparam int unsigned E_W = ADDRESS_BITS + $clog2(TABLE_ENTRIES) + 1;

  back_status_t   bk_status;
  queue_flags_t   q_flags;
  logic           q_push, q_pop;
  logic [E_W-1:0] q_wdata, q_rdata;

  tbbp_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_word_i (in_word_i),
    .back_i    (bk_status),
    .q_flags_i (q_flags),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  tbbp_queue #(
    .WIDTH(E_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .flags_o(q_flags)
  );

  tbbp_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_flags_i  (q_flags),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .status_o   (bk_status),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  `CHK_IMPL(a_no_accept_in_clear, clk_i, rst_ni, in_valid_i && !in_stall_o, !bk_status.clearing, "word accepted during table sweep")
  `CHK_IMPL(a_no_push_full, clk_i, rst_ni, q_push, !q_flags.full, "push into full queue")
  `CHK_IMPL(a_coll_counted, clk_i, rst_ni, out_valid_o && out_word_o.index_collision, out_word_o.collision_total != '0, "collision not counted")
  `CHK_NEXT(a_pop_spaced, clk_i, rst_ni, q_pop, !q_pop, "back popped on consecutive cycles")

endmodule

// ===== design/tbbp_queue.sv =====
// Small FIFO between the predictor front and back.
module tbbp_queue #(
  parameter int unsigned WIDTH = 75
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [WIDTH-1:0]      data_i,
  input  logic                  pop_i,
  output logic [WIDTH-1:0]      data_o,
  output tbbp_pkg::queue_flags_t flags_o
);
  import tbbp_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o        = mem_q[rd_ptr_q];
  assign flags_o.full  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign flags_o.empty = (count_q == '0);

endmodule

// ===== design/tbbp_front.sv =====
// Predictor front: takes branch words, reduces the address to a table index.
module tbbp_front #(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned ADDRESS_BITS  = 64
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_stall_o,
  input  tbbp_pkg::in_word_t                         in_word_i,
  input  tbbp_pkg::back_status_t                     back_i,
  input  tbbp_pkg::queue_flags_t                     q_flags_i,
  output logic                                       q_push_o,
  output logic [ADDRESS_BITS+$clog2(TABLE_ENTRIES):0] q_data_o
);
  import tbbp_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned RW    = IDX_W + 1;
  localparam bit          POW2  = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  localparam int unsigned NSTEP = (ADDRESS_BITS + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned PAD_W = NSTEP * DIGIT_W;
  localparam int unsigned SW    = $clog2(NSTEP);

  front_state_e state_q, state_d;

  logic [ADDRESS_BITS-1:0] in_addr;
  logic [ADDRESS_BITS-1:0] addr_q;
  logic                    taken_q;
  logic [IDX_W-1:0]        rem_q, rem_nx;
  logic [PAD_W-1:0]        shift_q;
  logic [SW-1:0]           step_q;
  logic                    accept, step;
  logic [RW-1:0]           r;
  logic [DIGIT_W-1:0]      digit;

  assign in_addr = in_word_i.branch_address[ADDRESS_BITS-1:0];

  // one address digit per cycle, restoring remainder
  always_comb begin
    r     = {1'b0, rem_q};
    digit = shift_q[PAD_W-1 -: DIGIT_W];
    for (int b = 0; b < DIGIT_W; b++) begin
      r = {r[IDX_W-1:0], digit[DIGIT_W-1-b]};
      if (r >= RW'(TABLE_ENTRIES)) begin
        r = r - RW'(TABLE_ENTRIES);
      end
    end
    rem_nx = r[IDX_W-1:0];
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    q_push_o   = 1'b0;
    step       = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        in_stall_o = back_i.clearing;
      end
      F_REDUCE: begin
        step = 1'b1;
        if (step_q == '0) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        in_stall_o = back_i.clearing || q_flags_i.full;
        q_push_o   = !q_flags_i.full;
        if (q_push_o) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
    accept = in_valid_i && !in_stall_o;
    if (accept) begin
      state_d = POW2 ? F_PUSH : F_REDUCE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q  <= in_addr;
      taken_q <= in_word_i.was_taken;
      rem_q   <= POW2 ? in_addr[IDX_W-1:0] : '0;
      shift_q <= PAD_W'(in_addr);
      step_q  <= SW'(NSTEP - 1);
    end else if (step) begin
      rem_q   <= rem_nx;
      shift_q <= shift_q << DIGIT_W;
      step_q  <= step_q - 1'b1;
    end
  end

  assign q_data_o = {addr_q, rem_q, taken_q};

endmodule

// ===== design/tbbp_back.sv =====
// Predictor back: counter and tag tables, statistics, result register.
module tbbp_back #(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned ADDRESS_BITS  = 64
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  tbbp_pkg::queue_flags_t                     q_flags_i,
  input  logic [ADDRESS_BITS+$clog2(TABLE_ENTRIES):0] q_data_i,
  output logic                                       q_pop_o,
  output tbbp_pkg::back_status_t                     status_o,
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output tbbp_pkg::out_word_t                        out_word_o
);
  import tbbp_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  typedef struct packed {
    logic [ADDRESS_BITS-1:0] addr;
    logic [IDX_W-1:0]        idx;
    logic                    taken;
  } entry_t;

  back_state_e state_q, state_d;

  entry_t                  head, ent_q;
  logic [IDX_W-1:0]        clr_idx_q, clr_idx_d;
  logic [1:0]              cnt_mem [TABLE_ENTRIES];
  logic [ADDRESS_BITS-1:0] tag_mem [TABLE_ENTRIES];
  logic [1:0]              cnt_rd_q;
  logic [ADDRESS_BITS-1:0] tag_rd_q;
  logic [CNT_W-1:0]        right_q, right_d, wrong_q, wrong_d, coll_q, coll_d;
  logic                    out_valid_q, out_valid_d;
  out_word_t               out_word_q, out_word_d;

  logic                    mem_we;
  logic [IDX_W-1:0]        mem_widx;
  logic [1:0]              mem_wcnt;
  logic [ADDRESS_BITS-1:0] mem_wtag;
  logic                    collide, pred, right, out_free;
  logic [1:0]              ctr_new;

  assign head     = entry_t'(q_data_i);
  assign collide  = (tag_rd_q != ent_q.addr);
  assign pred     = (cnt_rd_q >= CTR_TAKEN);
  assign right    = (pred == ent_q.taken);
  assign ctr_new  = ctr_step(cnt_rd_q, ent_q.taken);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_widx    = clr_idx_q;
    mem_wcnt    = CTR_MIN;
    mem_wtag    = '0;
    right_d     = right_q;
    wrong_d     = wrong_q;
    coll_d      = coll_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    unique case (state_q)
      B_CLEAR: begin
        mem_we = 1'b1;
        if (clr_idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_d = B_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + 1'b1;
        end
      end
      B_IDLE: begin
        if (!q_flags_i.empty) begin
          q_pop_o = 1'b1;
          state_d = B_UPDATE;
        end
      end
      B_UPDATE: begin
        if (out_free) begin
          mem_we   = 1'b1;
          mem_widx = ent_q.idx;
          mem_wcnt = ctr_new;
          mem_wtag = ent_q.addr;
          if (collide) begin
            coll_d = sat_inc(coll_q);
          end else if (right) begin
            right_d = sat_inc(right_q);
          end else begin
            wrong_d = sat_inc(wrong_q);
          end
          out_valid_d                = 1'b1;
          out_word_d.predicted_taken  = pred;
          out_word_d.prediction_right = right;
          out_word_d.index_collision  = collide;
          out_word_d.right_total      = right_d;
          out_word_d.wrong_total      = wrong_d;
          out_word_d.collision_total  = coll_d;
          state_d                    = B_IDLE;
        end
      end
      default: begin
        state_d = B_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_idx_q   <= '0;
      right_q     <= '0;
      wrong_q     <= '0;
      coll_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      right_q     <= right_d;
      wrong_q     <= wrong_d;
      coll_q      <= coll_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    if (q_pop_o) begin
      ent_q <= head;
    end
  end

  // tables: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cnt_mem[mem_widx] <= mem_wcnt;
      tag_mem[mem_widx] <= mem_wtag;
    end
    if (q_pop_o) begin
      cnt_rd_q <= cnt_mem[head.idx];
      tag_rd_q <= tag_mem[head.idx];
    end
  end

  assign status_o.clearing = (state_q == B_CLEAR);
  assign out_valid_o       = out_valid_q;
  assign out_word_o        = out_word_q;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench of the two-bit branch predictor unit.
module tb_top;
  import tbbp_pkg::*;

  localparam int unsigned TBL_DEPTH = 1024;
  localparam int unsigned HOT_SET   = 32;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  two_bit_branch_predictor_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  logic [1:0]        ctr_tbl [TBL_DEPTH];
  logic [ADDR_W-1:0] tag_tbl [TBL_DEPTH];
  logic [CNT_W-1:0]  right_cnt;
  logic [CNT_W-1:0]  wrong_cnt;
  logic [CNT_W-1:0]  coll_cnt;
  out_word_t         bimodal_results_q [$];
  int unsigned       mismatches;
  bit                idle_en;
  int                stall_left;
  logic [ADDR_W-1:0] hot_addr [HOT_SET];
  int unsigned       hot_bias [HOT_SET];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic out_word_t bimodal_lookup(input in_word_t w);
    out_word_t   r;
    int unsigned idx;
    logic [1:0]  c;
    idx = w.branch_address % TBL_DEPTH;
    r.index_collision = (tag_tbl[idx] != w.branch_address);
    if (r.index_collision) begin
      tag_tbl[idx] = w.branch_address;
      if (coll_cnt != CNT_MAX) coll_cnt++;
    end
    c = ctr_tbl[idx];
    r.predicted_taken  = c[1];
    r.prediction_right = (r.predicted_taken == w.was_taken);
    if (w.was_taken && c != 2'd3) c++;
    else if (!w.was_taken && c != 2'd0) c--;
    ctr_tbl[idx] = c;
    if (!r.index_collision) begin
      if (r.prediction_right) begin
        if (right_cnt != CNT_MAX) right_cnt++;
      end else begin
        if (wrong_cnt != CNT_MAX) wrong_cnt++;
      end
    end
    r.right_total     = right_cnt;
    r.wrong_total     = wrong_cnt;
    r.collision_total = coll_cnt;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $time);
    mismatches++;
  endtask

  task automatic send_branch(input logic [ADDR_W-1:0] addr, input logic taken);
    in_word_t w;
    w.branch_address = addr;
    w.was_taken      = taken;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    bimodal_results_q.push_back(bimodal_lookup(w));
  endtask

  // result stall bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : chk_words
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (bimodal_results_q.size() == 0) begin
        report_mismatch("unexpected word", 64'(out_word_o), 64'd0);
      end else begin
        want = bimodal_results_q.pop_front();
        if (out_word_o.predicted_taken !== want.predicted_taken)
          report_mismatch("predicted_taken", 64'(out_word_o.predicted_taken),
                          64'(want.predicted_taken));
        if (out_word_o.prediction_right !== want.prediction_right)
          report_mismatch("prediction_right", 64'(out_word_o.prediction_right),
                          64'(want.prediction_right));
        if (out_word_o.index_collision !== want.index_collision)
          report_mismatch("index_collision", 64'(out_word_o.index_collision),
                          64'(want.index_collision));
        if (out_word_o.right_total !== want.right_total)
          report_mismatch("right_total", 64'(out_word_o.right_total),
                          64'(want.right_total));
        if (out_word_o.wrong_total !== want.wrong_total)
          report_mismatch("wrong_total", 64'(out_word_o.wrong_total),
                          64'(want.wrong_total));
        if (out_word_o.collision_total !== want.collision_total)
          report_mismatch("collision_total", 64'(out_word_o.collision_total),
                          64'(want.collision_total));
      end
    end
  end

  // address zero matches the cleared tag; walk the counter to both ends
  task automatic test_counter_ends();
    send_branch('0, 1'b0);
    repeat (5) send_branch('0, 1'b1);
    repeat (5) send_branch('0, 1'b0);
    send_branch('1, 1'b1);
    send_branch('1, 1'b1);
  endtask

  // addresses aliasing on index 0 and on index 1023 replace each other's tag
  task automatic test_tag_collisions();
    send_branch(64'h400, 1'b1);
    send_branch(64'h8000_0000_0000_0000, 1'b0);
    send_branch('0, 1'b1);
    send_branch('0, 1'b1);
    send_branch(64'h3ff, 1'b0);
    send_branch('1, 1'b0);
    send_branch(64'h3ff, 1'b1);
    send_branch(64'h3ff, 1'b1);
    send_branch(64'h5555_5555_5555_5555, 1'b1);
    send_branch(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
  endtask

  task automatic test_random_stream(input int n);
    int unsigned       k;
    int unsigned       pick;
    logic [ADDR_W-1:0] a;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, HOT_SET - 1);
      if (pick < 70) begin
        send_branch(hot_addr[k], $urandom_range(0, 99) < hot_bias[k]);
      end else if (pick < 85) begin
        a = {$urandom, $urandom};
        a[9:0] = hot_addr[k][9:0];
        send_branch(a, 1'($urandom));
      end else begin
        send_branch({$urandom, $urandom}, 1'($urandom));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < TBL_DEPTH; i++) begin
      ctr_tbl[i] = 2'd0;
      tag_tbl[i] = '0;
    end
    for (int i = 0; i < HOT_SET; i++) begin
      hot_addr[i] = {$urandom, $urandom};
      case ($urandom_range(0, 2))
        0: hot_bias[i] = 5;
        1: hot_bias[i] = 50;
        default: hot_bias[i] = 95;
      endcase
    end
    hot_addr[0] = '0;
    right_cnt   = '0;
    wrong_cnt   = '0;
    coll_cnt    = '0;
    mismatches  = 0;
    stall_left  = 0;
    idle_en     = 1'b1;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    out_stall_i = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_counter_ends();
    test_tag_collisions();
    test_random_stream(1300);
    idle_en = 1'b0;
    test_random_stream(200);
    in_valid_i <= 1'b0;

    wait (bimodal_results_q.size() == 0);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
